// ===== rtl/tga_pkg.sv =====
`default_nettype none

package tga_pkg;

  localparam int unsigned DIM_W       = 16;
  localparam int unsigned PIX_COUNT_W = 2 * DIM_W;
  localparam int unsigned HDR_IDX_W   = 5;

  // Result kinds
  localparam logic [1:0] KIND_SIZE  = 2'd0;
  localparam logic [1:0] KIND_PIXEL = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_TYPE      = 3'd1;
  localparam logic [2:0] ERR_COLOR_MAP = 3'd2;
  localparam logic [2:0] ERR_PIX_SIZE  = 3'd3;
  localparam logic [2:0] ERR_EARLY_END = 3'd4;

  // Header byte offsets
  localparam logic [HDR_IDX_W-1:0] HDR_ID_LEN    = 5'd0;
  localparam logic [HDR_IDX_W-1:0] HDR_CMAP_KIND = 5'd1;
  localparam logic [HDR_IDX_W-1:0] HDR_IMG_KIND  = 5'd2;
  localparam logic [HDR_IDX_W-1:0] HDR_WIDTH_LO  = 5'd12;
  localparam logic [HDR_IDX_W-1:0] HDR_WIDTH_HI  = 5'd13;
  localparam logic [HDR_IDX_W-1:0] HDR_HEIGHT_LO = 5'd14;
  localparam logic [HDR_IDX_W-1:0] HDR_HEIGHT_HI = 5'd15;
  localparam logic [HDR_IDX_W-1:0] HDR_BPP       = 5'd16;
  localparam logic [HDR_IDX_W-1:0] HDR_LAST      = 5'd17;

  localparam logic [7:0] IMG_KIND_TRUECOLOR = 8'd2;
  localparam logic [7:0] BPP_24             = 8'd24;
  localparam logic [7:0] BPP_32             = 8'd32;
  localparam logic [7:0] ALPHA_OPAQUE       = 8'd255;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic             final_result;
    logic [2:0]       error_code;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/tga_if.sv =====
`default_nettype none

interface tga_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface tga_result_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                result_kind;
  logic [tga_pkg::DIM_W-1:0] image_width;
  logic [tga_pkg::DIM_W-1:0] image_height;
  logic [7:0]                red;
  logic [7:0]                green;
  logic [7:0]                blue;
  logic [7:0]                alpha;
  logic                      final_result;
  logic [2:0]                error_code;

  modport source (output valid, output result_kind, output image_width,
                  output image_height, output red, output green, output blue,
                  output alpha, output final_result, output error_code, input ready);
  modport sink   (input valid, input result_kind, input image_width,
                  input image_height, input red, input green, input blue,
                  input alpha, input final_result, input error_code, output ready);
endinterface

`default_nettype wire

// ===== rtl/tga_core.sv =====
`default_nettype none

module tga_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             take,
  input  wire logic [7:0]       data_byte,
  input  wire logic             end_of_stream,
  output logic                  res_valid,
  output tga_pkg::result_t      res
);

  typedef enum logic [1:0] {PH_HEADER, PH_SKIP, PH_PIXELS, PH_DRAIN} phase_t;

  phase_t                              phase, phase_next;
  logic [tga_pkg::HDR_IDX_W-1:0]       hdr_idx, hdr_idx_next;
  logic [7:0]                          id_len, id_len_next;
  logic [7:0]                          cmap_kind, cmap_kind_next;
  logic [7:0]                          img_kind, img_kind_next;
  logic [7:0]                          bpp, bpp_next;
  logic [tga_pkg::DIM_W-1:0]           width, width_next;
  logic [tga_pkg::DIM_W-1:0]           height, height_next;
  logic [7:0]                          skip_cnt, skip_cnt_next;
  logic [1:0]                          pix_idx, pix_idx_next;
  logic [23:0]                         partial, partial_next;
  logic [tga_pkg::PIX_COUNT_W-1:0]     pix_left, pix_left_next;
  logic [tga_pkg::PIX_COUNT_W-1:0]     area;
  logic                                clear;
  logic [1:0]                          last_idx;

  always_comb begin
    phase_next     = phase;
    hdr_idx_next   = hdr_idx;
    id_len_next    = id_len;
    cmap_kind_next = cmap_kind;
    img_kind_next  = img_kind;
    bpp_next       = bpp;
    width_next     = width;
    height_next    = height;
    skip_cnt_next  = skip_cnt;
    pix_idx_next   = pix_idx;
    partial_next   = partial;
    pix_left_next  = pix_left;
    clear          = 1'b0;
    res_valid      = 1'b0;
    res            = '0;
    last_idx       = (bpp == tga_pkg::BPP_32) ? 2'd3 : 2'd2;

    unique case (phase)
      PH_SKIP: begin
        skip_cnt_next = skip_cnt - 8'd1;
        if (end_of_stream) begin
          res_valid = 1'b1;
          res.result_kind  = tga_pkg::KIND_ERROR;
          res.error_code   = tga_pkg::ERR_EARLY_END;
          res.final_result = 1'b1;
          clear = 1'b1;
        end else if (skip_cnt_next == 8'd0) begin
          phase_next = PH_PIXELS;
        end
      end

      PH_PIXELS: begin
        if (pix_idx < last_idx) begin
          case (pix_idx)
            2'd0:    partial_next[7:0]   = partial[7:0] | data_byte;
            2'd1:    partial_next[15:8]  = partial[15:8] | data_byte;
            2'd2:    partial_next[23:16] = partial[23:16] | data_byte;
            default: partial_next        = partial;
          endcase
          pix_idx_next = pix_idx + 2'd1;
          if (end_of_stream) begin
            res_valid = 1'b1;
            res.result_kind  = tga_pkg::KIND_ERROR;
            res.error_code   = tga_pkg::ERR_EARLY_END;
            res.final_result = 1'b1;
            clear = 1'b1;
          end
        end else begin
          partial_next  = '0;
          pix_idx_next  = 2'd0;
          pix_left_next = pix_left - tga_pkg::PIX_COUNT_W'(1);
          res_valid     = 1'b1;
          if (pix_left_next == '0) begin
            res.result_kind  = tga_pkg::KIND_PIXEL;
            res.final_result = 1'b1;
            if (end_of_stream) clear = 1'b1;
            else phase_next = PH_DRAIN;
          end else if (end_of_stream) begin
            res.result_kind  = tga_pkg::KIND_ERROR;
            res.error_code   = tga_pkg::ERR_EARLY_END;
            res.final_result = 1'b1;
            clear = 1'b1;
          end else begin
            res.result_kind = tga_pkg::KIND_PIXEL;
          end
          if (res.result_kind == tga_pkg::KIND_PIXEL) begin
            res.blue  = partial[7:0];
            res.green = partial[15:8];
            if (last_idx == 2'd3) begin
              res.red   = partial[23:16];
              res.alpha = data_byte;
            end else begin
              res.red   = data_byte;
              res.alpha = tga_pkg::ALPHA_OPAQUE;
            end
          end
        end
      end

      PH_DRAIN: begin
        if (end_of_stream) clear = 1'b1;
      end

      PH_HEADER: begin
        case (hdr_idx)
          tga_pkg::HDR_ID_LEN:    id_len_next    = data_byte;
          tga_pkg::HDR_CMAP_KIND: cmap_kind_next = data_byte;
          tga_pkg::HDR_IMG_KIND:  img_kind_next  = data_byte;
          tga_pkg::HDR_WIDTH_LO:  width_next     = {width[15:8], data_byte};
          tga_pkg::HDR_WIDTH_HI:  width_next     = {data_byte, width[7:0]};
          tga_pkg::HDR_HEIGHT_LO: height_next    = {height[15:8], data_byte};
          tga_pkg::HDR_HEIGHT_HI: height_next    = {data_byte, height[7:0]};
          tga_pkg::HDR_BPP:       bpp_next       = data_byte;
          default:                ;
        endcase
        if (hdr_idx < tga_pkg::HDR_LAST) begin
          hdr_idx_next = hdr_idx + tga_pkg::HDR_IDX_W'(1);
          if (end_of_stream) begin
            res_valid = 1'b1;
            res.result_kind  = tga_pkg::KIND_ERROR;
            res.error_code   = tga_pkg::ERR_EARLY_END;
            res.final_result = 1'b1;
            clear = 1'b1;
          end
        end else begin
          res_valid = 1'b1;
          if (img_kind != tga_pkg::IMG_KIND_TRUECOLOR ||
              cmap_kind != 8'd0 ||
              (bpp != tga_pkg::BPP_24 && bpp != tga_pkg::BPP_32)) begin
            res.result_kind  = tga_pkg::KIND_ERROR;
            res.final_result = 1'b1;
            if (img_kind != tga_pkg::IMG_KIND_TRUECOLOR) res.error_code = tga_pkg::ERR_TYPE;
            else if (cmap_kind != 8'd0) res.error_code = tga_pkg::ERR_COLOR_MAP;
            else res.error_code = tga_pkg::ERR_PIX_SIZE;
            if (end_of_stream) clear = 1'b1;
            else phase_next = PH_DRAIN;
          end else if (width == '0 || height == '0) begin
            res.result_kind  = tga_pkg::KIND_SIZE;
            res.image_width  = width;
            res.image_height = height;
            res.final_result = 1'b1;
            if (end_of_stream) clear = 1'b1;
            else phase_next = PH_DRAIN;
          end else if (end_of_stream) begin
            res.result_kind  = tga_pkg::KIND_ERROR;
            res.error_code   = tga_pkg::ERR_EARLY_END;
            res.final_result = 1'b1;
            clear = 1'b1;
          end else begin
            res.result_kind  = tga_pkg::KIND_SIZE;
            res.image_width  = width;
            res.image_height = height;
            pix_left_next    = area;
            skip_cnt_next    = id_len;
            pix_idx_next     = 2'd0;
            partial_next     = '0;
            phase_next       = (id_len != 8'd0) ? PH_SKIP : PH_PIXELS;
          end
        end
      end

      default: phase_next = PH_HEADER;
    endcase
  end

  // Product of width and height; settles while the last two header bytes pass
  always_ff @(posedge clk) begin
    area <= {{tga_pkg::DIM_W{1'b0}}, width} * {{tga_pkg::DIM_W{1'b0}}, height};
  end

  always_ff @(posedge clk) begin
    if (rst || (take && clear)) begin
      phase     <= PH_HEADER;
      hdr_idx   <= '0;
      id_len    <= '0;
      cmap_kind <= '0;
      img_kind  <= '0;
      bpp       <= '0;
      width     <= '0;
      height    <= '0;
      skip_cnt  <= '0;
      pix_idx   <= '0;
      partial   <= '0;
      pix_left  <= '0;
    end else if (take) begin
      phase     <= phase_next;
      hdr_idx   <= hdr_idx_next;
      id_len    <= id_len_next;
      cmap_kind <= cmap_kind_next;
      img_kind  <= img_kind_next;
      bpp       <= bpp_next;
      width     <= width_next;
      height    <= height_next;
      skip_cnt  <= skip_cnt_next;
      pix_idx   <= pix_idx_next;
      partial   <= partial_next;
      pix_left  <= pix_left_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tga_outq.sv =====
`default_nettype none

module tga_outq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire tga_pkg::result_t push_data,
  output logic                  space,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output tga_pkg::result_t      out_data
);

  logic             skid_valid;
  tga_pkg::result_t skid_data;
  logic             pop;

  assign pop   = out_valid && out_ready;
  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
        out_data  <= push_data;
      end else begin
        skid_valid <= 1'b1;
        skid_data  <= push_data;
      end
    end else if (pop) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tga_uncompressed_rgba_decoder.sv =====
`default_nettype none

// Channel   Dir  Payload                                       Transfer
// bytes     in   data_byte[7:0], end_of_stream                 valid && ready
// results   out  result_kind, image_width, image_height, red,  valid && ready
//                green, blue, alpha, final_result, error_code
//
// Takes one file byte per cycle while bytes.ready is high; results are
// registered in the output or skid register. The per-byte parse is one
// step of the header/pixel state machine, and width*height comes from a
// registered multiplier that settles before the last header byte arrives.
// rst is synchronous and clears the parser state and both valid flags.
// bytes.ready drops only while two results wait: one in the output register
// and one in the skid register behind it.

module tga_uncompressed_rgba_decoder (
  input  wire logic      clk,
  input  wire logic      rst,
  tga_byte_if.sink       bytes,
  tga_result_if.source   results
);

  logic             take;
  logic             res_valid;
  logic             space;
  tga_pkg::result_t res;
  tga_pkg::result_t out_data;

  // Accept a byte whenever the skid slot is free
  assign bytes.ready = space;
  assign take        = bytes.valid && space;

  tga_core u_core (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .data_byte     (bytes.data_byte),
    .end_of_stream (bytes.end_of_stream),
    .res_valid     (res_valid),
    .res           (res)
  );

  // Hold results until the sink takes them
  tga_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (take && res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_data  (out_data)
  );

  assign results.result_kind  = out_data.result_kind;
  assign results.image_width  = out_data.image_width;
  assign results.image_height = out_data.image_height;
  assign results.red          = out_data.red;
  assign results.green        = out_data.green;
  assign results.blue         = out_data.blue;
  assign results.alpha        = out_data.alpha;
  assign results.final_result = out_data.final_result;
  assign results.error_code   = out_data.error_code;

endmodule

`default_nettype wire

// ===== rtl/tga_check.sv =====
`default_nettype none

module tga_check (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [1:0]                result_kind,
  input wire logic [tga_pkg::DIM_W-1:0] image_width,
  input wire logic [tga_pkg::DIM_W-1:0] image_height,
  input wire logic                      final_result,
  input wire logic [2:0]                error_code
);

  // Stalled result stays valid and keeps its kind, size and error code
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_kind) &&
      $stable(image_width) && $stable(image_height) && $stable(error_code))
    else $error("stalled result changed");

  a_error_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == tga_pkg::KIND_ERROR |->
      final_result && error_code != tga_pkg::ERR_NONE)
    else $error("error result not final or without code");

  a_size_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == tga_pkg::KIND_SIZE |->
      (final_result == (image_width == '0 || image_height == '0)))
    else $error("size result final flag disagrees with empty image");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind tga_uncompressed_rgba_decoder tga_check u_check (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .result_kind  (results.result_kind),
  .image_width  (results.image_width),
  .image_height (results.image_height),
  .final_result (results.final_result),
  .error_code   (results.error_code)
);

`default_nettype wire

// ===== tb/tga_uncompressed_rgba_decoder_tb.sv =====
module tga_uncompressed_rgba_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One file byte as the sender presents it.
  typedef struct {
    logic [7:0] data;
    logic       eos;
  } file_byte_t;

  // Where the decoder stands in the current file.
  typedef enum logic [1:0] {
    ST_HEADER,
    ST_ID_SKIP,
    ST_PIXELS,
    ST_DRAIN
  } parse_stage_t;

  logic clk = 1'b0;
  logic rst;

  tga_byte_if   bytes_if ();
  tga_result_if results_if ();

  tga_uncompressed_rgba_decoder i_dut (
    .clk     (clk),
    .rst     (rst),
    .bytes   (bytes_if),
    .results (results_if)
  );

  always #5 clk = ~clk;

  // Bytes still to be sent, and decoder results still to arrive.
  file_byte_t        byte_queue[$];
  tga_pkg::result_t  expected_results[$];
  int unsigned       fail_count = 0;

  // Transfer flags seen at the last rising edge, read by the drivers.
  logic        byte_taken   = 1'b0;
  logic        result_taken = 1'b0;
  int unsigned byte_wait    = 0;
  int unsigned result_wait  = 0;
  logic        byte_calm    = 1'b0;
  logic        result_calm  = 1'b1;

  // Decoder state as the testbench tracks it.
  parse_stage_t stage;
  logic [4:0]   hdr_pos;
  logic [7:0]   id_len_q;
  logic [7:0]   cmap_kind_q;
  logic [7:0]   img_kind_q;
  logic [7:0]   bpp_q;
  logic [15:0]  width_q;
  logic [15:0]  height_q;
  logic [7:0]   id_left;
  logic [1:0]   pix_byte_pos;
  logic [23:0]  pix_partial;
  logic [31:0]  pix_left;

  // Draw a wait length; calm stretches never wait.
  function automatic int unsigned draw_wait(logic calm);
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic void clear_tracker();
    stage        = ST_HEADER;
    hdr_pos      = '0;
    id_len_q     = '0;
    cmap_kind_q  = '0;
    img_kind_q   = '0;
    bpp_q        = '0;
    width_q      = '0;
    height_q     = '0;
    id_left      = '0;
    pix_byte_pos = '0;
    pix_partial  = '0;
    pix_left     = '0;
  endfunction

  function automatic void add_result(logic [1:0] kind, logic [15:0] w, logic [15:0] h,
                                     logic [7:0] r, logic [7:0] g, logic [7:0] bl,
                                     logic [7:0] a, logic fin, logic [2:0] err);
    tga_pkg::result_t res;
    res.result_kind  = kind;
    res.image_width  = w;
    res.image_height = h;
    res.red          = r;
    res.green        = g;
    res.blue         = bl;
    res.alpha        = a;
    res.final_result = fin;
    res.error_code   = err;
    expected_results.push_back(res);
  endfunction

  // An error is always the last result of its file; the end of stream
  // restarts header parsing, otherwise drop bytes until it comes.
  function automatic void abort_file(logic [2:0] err, logic eos);
    add_result(tga_pkg::KIND_ERROR, '0, '0, '0, '0, '0, '0, 1'b1, err);
    if (eos) begin
      clear_tracker();
    end else begin
      stage = ST_DRAIN;
    end
  endfunction

  // Advance the tracked decoder by one accepted byte and queue what it yields.
  function automatic void decode_byte(logic [7:0] b, logic eos);
    logic [1:0]  last_pos;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  bl;
    logic [7:0]  a;
    logic [31:0] total;
    case (stage)
      ST_ID_SKIP: begin
        id_left = id_left - 8'd1;
        if (eos) begin
          abort_file(tga_pkg::ERR_EARLY_END, 1'b1);
        end else if (id_left == 8'd0) begin
          stage = ST_PIXELS;
        end
      end
      ST_PIXELS: begin
        last_pos = (bpp_q == tga_pkg::BPP_32) ? 2'd3 : 2'd2;
        if (pix_byte_pos < last_pos) begin
          // collect B, G (and R for 32-bit) in file order
          pix_partial  = pix_partial | (24'(b) << (8 * pix_byte_pos));
          pix_byte_pos = pix_byte_pos + 2'd1;
          if (eos) begin
            abort_file(tga_pkg::ERR_EARLY_END, 1'b1);
          end
        end else begin
          bl = pix_partial[7:0];
          g  = pix_partial[15:8];
          if (last_pos == 2'd3) begin
            r = pix_partial[23:16];
            a = b;
          end else begin
            r = b;
            a = tga_pkg::ALPHA_OPAQUE;
          end
          pix_partial  = '0;
          pix_byte_pos = '0;
          pix_left     = pix_left - 32'd1;
          if (pix_left == 32'd0) begin
            add_result(tga_pkg::KIND_PIXEL, '0, '0, r, g, bl, a, 1'b1, tga_pkg::ERR_NONE);
            if (eos) begin
              clear_tracker();
            end else begin
              stage = ST_DRAIN;
            end
          end else if (eos) begin
            // a pixel that is not the last one on the final byte is lost
            abort_file(tga_pkg::ERR_EARLY_END, 1'b1);
          end else begin
            add_result(tga_pkg::KIND_PIXEL, '0, '0, r, g, bl, a, 1'b0, tga_pkg::ERR_NONE);
          end
        end
      end
      ST_DRAIN: begin
        if (eos) begin
          clear_tracker();
        end
      end
      default: begin
        case (hdr_pos)
          tga_pkg::HDR_ID_LEN:    id_len_q       = b;
          tga_pkg::HDR_CMAP_KIND: cmap_kind_q    = b;
          tga_pkg::HDR_IMG_KIND:  img_kind_q     = b;
          tga_pkg::HDR_WIDTH_LO:  width_q[7:0]   = b;
          tga_pkg::HDR_WIDTH_HI:  width_q[15:8]  = b;
          tga_pkg::HDR_HEIGHT_LO: height_q[7:0]  = b;
          tga_pkg::HDR_HEIGHT_HI: height_q[15:8] = b;
          tga_pkg::HDR_BPP:       bpp_q          = b;
          default: ;
        endcase
        if (hdr_pos < tga_pkg::HDR_LAST) begin
          hdr_pos = hdr_pos + 5'd1;
          if (eos) begin
            abort_file(tga_pkg::ERR_EARLY_END, 1'b1);
          end
        end else if (img_kind_q != tga_pkg::IMG_KIND_TRUECOLOR) begin
          abort_file(tga_pkg::ERR_TYPE, eos);
        end else if (cmap_kind_q != 8'd0) begin
          abort_file(tga_pkg::ERR_COLOR_MAP, eos);
        end else if (bpp_q != tga_pkg::BPP_24 && bpp_q != tga_pkg::BPP_32) begin
          abort_file(tga_pkg::ERR_PIX_SIZE, eos);
        end else begin
          total = 32'(width_q) * 32'(height_q);
          if (total == 32'd0) begin
            // empty image: the size report closes the file
            add_result(tga_pkg::KIND_SIZE, width_q, height_q, '0, '0, '0, '0, 1'b1,
                       tga_pkg::ERR_NONE);
            if (eos) begin
              clear_tracker();
            end else begin
              stage = ST_DRAIN;
            end
          end else if (eos) begin
            abort_file(tga_pkg::ERR_EARLY_END, 1'b1);
          end else begin
            pix_left     = total;
            id_left      = id_len_q;
            pix_byte_pos = '0;
            pix_partial  = '0;
            stage        = (id_len_q != 8'd0) ? ST_ID_SKIP : ST_PIXELS;
            add_result(tga_pkg::KIND_SIZE, width_q, height_q, '0, '0, '0, '0, 1'b0,
                       tga_pkg::ERR_NONE);
          end
        end
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Build one TGA file and queue it; cut, when in range, is the index of the
  // byte that carries end of stream, otherwise the whole file goes out.
  task automatic send_file(input logic [7:0] id_len, cmap, kind,
                           input logic [15:0] w, h, input logic [7:0] bpp,
                           input int unsigned pixels, trailing, input int cut);
    logic [7:0]  file[$];
    int unsigned last;
    file_byte_t  item;
    file.push_back(id_len);
    file.push_back(cmap);
    file.push_back(kind);
    // colour map spec and origin: read and ignored
    repeat (9) file.push_back(8'($urandom));
    file.push_back(w[7:0]);
    file.push_back(w[15:8]);
    file.push_back(h[7:0]);
    file.push_back(h[15:8]);
    file.push_back(bpp);
    file.push_back(8'($urandom));
    repeat (id_len) file.push_back(8'($urandom));
    repeat (pixels * ((bpp == tga_pkg::BPP_32) ? 4 : 3)) file.push_back(8'($urandom));
    repeat (trailing) file.push_back(8'($urandom));
    last = (cut >= 0 && cut < file.size()) ? cut : file.size() - 1;
    for (int i = 0; i <= last; i++) begin
      item.data = file[i];
      item.eos  = (i == last);
      byte_queue.push_back(item);
    end
  endtask

  // Sample both channels at the rising edge: track accepted bytes first,
  // then match any result transfer against the oldest expectation.
  always @(posedge clk) begin : track_and_check
    tga_pkg::result_t got;
    tga_pkg::result_t want;
    byte_taken   <= !rst && bytes_if.valid && bytes_if.ready;
    result_taken <= !rst && results_if.valid && results_if.ready;
    if (rst) begin
      clear_tracker();
    end else begin
      if (bytes_if.valid && bytes_if.ready) begin
        decode_byte(bytes_if.data_byte, bytes_if.end_of_stream);
      end
      if (results_if.valid && results_if.ready) begin
        got.result_kind  = results_if.result_kind;
        got.image_width  = results_if.image_width;
        got.image_height = results_if.image_height;
        got.red          = results_if.red;
        got.green        = results_if.green;
        got.blue         = results_if.blue;
        got.alpha        = results_if.alpha;
        got.final_result = results_if.final_result;
        got.error_code   = results_if.error_code;
        if (expected_results.size() == 0) begin
          $error("result_kind: expected no result, got %0d", got.result_kind);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("result_kind", want.result_kind, got.result_kind);
          check_field("image_width", want.image_width, got.image_width);
          check_field("image_height", want.image_height, got.image_height);
          check_field("red", want.red, got.red);
          check_field("green", want.green, got.green);
          check_field("blue", want.blue, got.blue);
          check_field("alpha", want.alpha, got.alpha);
          check_field("final_result", want.final_result, got.final_result);
          check_field("error_code", want.error_code, got.error_code);
        end
      end
    end
  end

  // Byte sender: hold a byte until it is taken, then idle for the drawn
  // number of cycles before presenting the next one.
  always @(negedge clk) begin : drive_bytes
    file_byte_t next_item;
    if (rst) begin
      bytes_if.valid <= 1'b0;
    end else if (bytes_if.valid && !byte_taken) begin
      // hold until the transfer happens
    end else if (byte_wait > 0) begin
      bytes_if.valid <= 1'b0;
      byte_wait      <= byte_wait - 1;
    end else if (byte_queue.size() > 0) begin
      next_item                = byte_queue.pop_front();
      bytes_if.valid          <= 1'b1;
      bytes_if.data_byte      <= next_item.data;
      bytes_if.end_of_stream  <= next_item.eos;
      byte_wait               <= draw_wait(byte_calm);
      if ($urandom_range(0, 39) == 0) begin
        byte_calm <= !byte_calm;
      end
    end else begin
      bytes_if.valid <= 1'b0;
    end
  end

  // Result receiver: stall after a transfer for the drawn number of cycles,
  // and now and then, outside calm stretches, drop ready for a drawn wait.
  always @(negedge clk) begin : drive_ready
    int unsigned n;
    if (rst) begin
      results_if.ready <= 1'b0;
    end else if (result_taken) begin
      n = draw_wait(result_calm);
      results_if.ready <= (n == 0);
      result_wait      <= (n == 0) ? 0 : n - 1;
      if ($urandom_range(0, 39) == 0) begin
        result_calm <= !result_calm;
      end
    end else if (result_wait > 0) begin
      results_if.ready <= 1'b0;
      result_wait      <= result_wait - 1;
    end else if (!result_calm && $urandom_range(0, 7) == 0) begin
      results_if.ready <= 1'b0;
      result_wait      <= $urandom_range(0, 12);
    end else begin
      results_if.ready <= 1'b1;
    end
  end

  initial begin : stimulus
    int unsigned shape;
    int unsigned pixels;
    int unsigned trailing;
    int          cut;
    logic [7:0]  id_len;
    logic [7:0]  cmap;
    logic [7:0]  kind;
    logic [7:0]  bpp;
    logic [15:0] w;
    logic [15:0] h;

    rst                    = 1'b1;
    bytes_if.valid         = 1'b0;
    bytes_if.data_byte     = '0;
    bytes_if.end_of_stream = 1'b0;
    results_if.ready       = 1'b0;

    // Directed files: a one-pixel 24-bit and a two-pixel 32-bit image, every header
    // error, empty images, and end of stream in each part of a file.
    send_file(8'd0, 8'd0, tga_pkg::IMG_KIND_TRUECOLOR, 16'd1, 16'd1, tga_pkg::BPP_24,
              1, 0, -1);
    send_file(8'd2, 8'd0, tga_pkg::IMG_KIND_TRUECOLOR, 16'd2, 16'd1, tga_pkg::BPP_32,
              2, 2, -1);
    send_file(8'd0, 8'd0, 8'hFF, 16'd1, 16'd1, tga_pkg::BPP_24, 1, 1, -1);
    send_file(8'd0, 8'h01, tga_pkg::IMG_KIND_TRUECOLOR, 16'd1, 16'd1, tga_pkg::BPP_24,
              0, 1, -1);
    send_file(8'd0, 8'd0, tga_pkg::IMG_KIND_TRUECOLOR, 16'd1, 16'd1, 8'd16, 0, 1, -1);
    // every check fails here; the type check wins
    send_file(8'd0, 8'hFF, 8'd0, 16'd1, 16'd1, 8'd0, 0, 0, -1);
    send_file(8'd0, 8'd0, tga_pkg::IMG_KIND_TRUECOLOR, 16'd0, 16'hFFFF, tga_pkg::BPP_32,
              0, 0, -1);
    send_file(8'd0, 8'd0, tga_pkg::IMG_KIND_TRUECOLOR, 16'hFFFF, 16'd0, tga_pkg::BPP_24,
              0, 2, -1);
    // end of stream on the last header byte, with and without a header error
    send_file(8'd0, 8'd0, tga_pkg::IMG_KIND_TRUECOLOR, 16'd2, 16'd2, tga_pkg::BPP_24,
              4, 0, 17);
    send_file(8'd0, 8'd0, 8'd3, 16'd2, 16'd2, tga_pkg::BPP_24, 0, 0, 17);
    // early end inside the header, the ID field, a pixel, and on a
    // completed pixel that is not the last one
    send_file(8'd0, 8'd0, tga_pkg::IMG_KIND_TRUECOLOR, 16'd1, 16'd1, tga_pkg::BPP_24,
              1, 0, 5);
    send_file(8'd3, 8'd0, tga_pkg::IMG_KIND_TRUECOLOR, 16'd1, 16'd1, tga_pkg::BPP_24,
              1, 0, 19);
    send_file(8'd0, 8'd0, tga_pkg::IMG_KIND_TRUECOLOR, 16'd2, 16'd1, tga_pkg::BPP_32,
              2, 0, 19);
    send_file(8'd0, 8'd0, tga_pkg::IMG_KIND_TRUECOLOR, 16'd2, 16'd1, tga_pkg::BPP_24,
              2, 0, 20);
    send_file(8'd0, 8'd0, tga_pkg::IMG_KIND_TRUECOLOR, 16'hFFFF, 16'hFFFF, tga_pkg::BPP_32,
              2, 0, -1);

    // Random files: mostly well-formed with random content, the rest with
    // header errors, early ends or huge sizes cut short.
    while (byte_queue.size() < 1250) begin
      shape    = $urandom_range(0, 9);
      id_len   = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
      cmap     = 8'd0;
      kind     = tga_pkg::IMG_KIND_TRUECOLOR;
      w        = 16'($urandom_range(0, 4));
      h        = 16'($urandom_range(0, 4));
      bpp      = ($urandom_range(0, 1) == 0) ? tga_pkg::BPP_24 : tga_pkg::BPP_32;
      trailing = $urandom_range(0, 3);
      cut      = -1;
      case (shape)
        7: begin
          if ($urandom_range(0, 1) == 0) kind = 8'($urandom);
          if ($urandom_range(0, 1) == 0) cmap = 8'($urandom);
          if ($urandom_range(0, 1) == 0) bpp = 8'($urandom);
        end
        8: cut = $urandom_range(0, 40);
        9: begin
          w = 16'($urandom);
          h = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'd1;
        end
        default: ;
      endcase
      pixels = (32'(w) * 32'(h) > 32'd16) ? $urandom_range(0, 3) : 32'(w) * 32'(h);
      send_file(id_len, cmap, kind, w, h, bpp, pixels, trailing, cut);
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for every byte to be taken and every result to arrive, then
    // leave time for a stray result to show up.
    while (byte_queue.size() != 0 || bytes_if.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hang guard, well beyond the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
